@@ design/hgl_pkg.sv @@
package hgl_pkg;

    // Index width wide enough for any grid row or column count up to 64
    localparam int IDX_W = 7;
    localparam int ROW_W = 5;
    localparam int COL_W = 5;
    localparam int OP_W  = 2;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_STEP  = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE  = 1'b0,
        ST_FLUSH = 1'b1
    } state_t;

    typedef struct packed {
        logic             step;
        logic             wr_en;
        logic [COL_W-1:0] column;
        logic             alive;
    } cell_ctrl_t;

endpackage

@@ design/hgl_if.sv @@
interface hgl_in_if
    import hgl_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  operation;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             alive_in;

    modport source (output valid, output operation, output row, output column,
                    output alive_in, input ready);
    modport sink (input valid, input operation, input row, input column,
                  input alive_in, output ready);
endinterface

interface hgl_out_if;
    logic valid;
    logic ready;
    logic alive_out;
    logic any_change;

    modport source (output valid, output alive_out, output any_change, input ready);
    modport sink (input valid, input alive_out, input any_change, output ready);
endinterface

@@ design/hgl_row_cell.sv @@
module hgl_row_cell
    import hgl_pkg::*;
#(
    parameter int WIDTH   = 32,
    parameter bit ODD_ROW = 1'b0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  cell_ctrl_t       ctrl,
    input  logic [WIDTH-1:0] above,
    input  logic [WIDTH-1:0] below,
    output logic [WIDTH-1:0] row_bits,
    output logic             changed
);

    logic [WIDTH-1:0] row_reg;
    logic [WIDTH-1:0] row_next;
    logic             changed_reg;
    logic             changed_next;
    logic [WIDTH-1:0] gen_bits;
    logic [WIDTH+1:0] own_pad;
    logic [WIDTH+1:0] up_pad;
    logic [WIDTH+1:0] dn_pad;
    logic [2:0]       n_count [WIDTH];

    // Pad with dead cells so off-grid neighbors read as zero
    assign own_pad = {1'b0, row_reg, 1'b0};
    assign up_pad  = {1'b0, above, 1'b0};
    assign dn_pad  = {1'b0, below, 1'b0};

    always_comb
    begin
        int lo;
        lo = 0;
        for (int x = 0; x < WIDTH; x++)
        begin
            // Odd rows sit half a cell right: vertical neighbors are x and x+1
            lo = ODD_ROW ? x + 1 : x;
            n_count[x] = 3'(own_pad[x]) + 3'(own_pad[x+2])
                       + 3'(up_pad[lo]) + 3'(up_pad[lo+1])
                       + 3'(dn_pad[lo]) + 3'(dn_pad[lo+1]);
            if (row_reg[x])
                gen_bits[x] = (n_count[x] == 3'd1) || (n_count[x] == 3'd2);
            else
                gen_bits[x] = (n_count[x] == 3'd2);
        end
    end

    always_comb
    begin
        row_next     = row_reg;
        changed_next = changed_reg;
        if (ctrl.step)
        begin
            row_next     = gen_bits;
            changed_next = |(gen_bits ^ row_reg);
        end
        else if (ctrl.wr_en)
        begin
            for (int x = 0; x < WIDTH; x++)
            begin
                if ({2'b0, ctrl.column} == IDX_W'(x))
                    row_next[x] = ctrl.alive;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg     <= '0;
            changed_reg <= 1'b0;
        end
        else
        begin
            row_reg     <= row_next;
            changed_reg <= changed_next;
        end
    end

    assign row_bits = row_reg;
    assign changed  = changed_reg;

endmodule

@@ design/hex_grid_life_step.sv @@
// Write and read: the result is loaded into the output register at the transfer edge,
// one item per cycle while the result side keeps up and no step is being flushed.
// Generation step: the row cells all update at the transfer edge, the next cycle
// merges their change flags into the result; the input is not ready during that flush.
// Reset (rst_n low, asynchronous) clears every cell to dead and empties the output.
module hex_grid_life_step
    import hgl_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32
)
(
    input  logic   clk,
    input  logic   rst_n,
    hgl_in_if.sink req,
    hgl_out_if.source rsp
);

    logic [GRID_WIDTH-1:0]  row_bits [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] change_vec;
    cell_ctrl_t             cell_ctrl [GRID_HEIGHT];

    state_t state_reg;
    state_t state_next;
    logic   in_ready;
    logic   accept;
    logic   is_write;
    logic   is_read;
    logic   is_step;
    logic   on_grid;
    logic   read_bit;

    logic   out_valid_reg;
    logic   out_valid_next;
    logic   alive_out_reg;
    logic   alive_out_next;
    logic   any_change_reg;
    logic   any_change_next;
    logic   load_out;

    assign accept   = req.valid && in_ready;
    assign is_write = (req.operation == OP_WRITE);
    assign is_read  = (req.operation == OP_READ);
    assign is_step  = (req.operation == OP_STEP);
    assign on_grid  = ({2'b0, req.row} < IDX_W'(GRID_HEIGHT))
                   && ({2'b0, req.column} < IDX_W'(GRID_WIDTH));

    genvar gy;
    generate
        for (gy = 0; gy < GRID_HEIGHT; gy++)
        begin : g_row
            logic [GRID_WIDTH-1:0] above;
            logic [GRID_WIDTH-1:0] below;

            if (gy == 0)
            begin : g_top
                assign above = '0;
            end
            else
            begin : g_up
                assign above = row_bits[gy-1];
            end

            if (gy == GRID_HEIGHT - 1)
            begin : g_bottom
                assign below = '0;
            end
            else
            begin : g_dn
                assign below = row_bits[gy+1];
            end

            assign cell_ctrl[gy].step   = accept && is_step;
            assign cell_ctrl[gy].wr_en  = accept && is_write && on_grid
                                       && ({2'b0, req.row} == IDX_W'(gy));
            assign cell_ctrl[gy].column = req.column;
            assign cell_ctrl[gy].alive  = req.alive_in;

            hgl_row_cell #(
                .WIDTH   (GRID_WIDTH),
                .ODD_ROW ((gy % 2) == 1)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl[gy]),
                .above    (above),
                .below    (below),
                .row_bits (row_bits[gy]),
                .changed  (change_vec[gy])
            );
        end
    endgenerate

    // Pick the addressed cell for a read
    always_comb
    begin
        logic [GRID_WIDTH-1:0] sel_row;
        sel_row  = '0;
        read_bit = 1'b0;
        for (int y = 0; y < GRID_HEIGHT; y++)
        begin
            if ({2'b0, req.row} == IDX_W'(y))
                sel_row = row_bits[y];
        end
        for (int x = 0; x < GRID_WIDTH; x++)
        begin
            if ({2'b0, req.column} == IDX_W'(x))
                read_bit = sel_row[x];
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && is_step)
                    state_next = ST_FLUSH;
            end
            ST_FLUSH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:  in_ready = !out_valid_reg || rsp.ready;
            ST_FLUSH: in_ready = 1'b0;
            default:  in_ready = 1'b0;
        endcase
    end

    // Output register; a step was only taken when this register was draining
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        alive_out_next  = alive_out_reg;
        any_change_next = any_change_reg;
        load_out        = 1'b0;
        if (state_reg == ST_FLUSH)
        begin
            load_out        = 1'b1;
            alive_out_next  = 1'b0;
            any_change_next = |change_vec;
        end
        else if (accept && !is_step)
        begin
            load_out        = 1'b1;
            any_change_next = 1'b0;
            if (is_write)
                alive_out_next = on_grid && req.alive_in;
            else if (is_read)
                alive_out_next = on_grid && read_bit;
            else
                alive_out_next = 1'b0;
        end
        if (load_out)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        alive_out_reg  <= alive_out_next;
        any_change_reg <= any_change_next;
    end

    assign req.ready      = in_ready;
    assign rsp.valid      = out_valid_reg;
    assign rsp.alive_out  = alive_out_reg;
    assign rsp.any_change = any_change_reg;

    a_step_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_step) |=> (state_reg == ST_FLUSH))
        else $error("step transfer not followed by flush");

    a_flush_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> !in_ready)
        else $error("input ready during flush");

    a_flush_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |=> (out_valid_reg && !alive_out_reg))
        else $error("step result missing after flush");

    a_access_result: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !is_step) |=> (out_valid_reg && !any_change_reg))
        else $error("access result missing");

endmodule
